### rtl/cau_pkg.sv
// Package for the complex arithmetic unit: defaults, operation and status codes.
`default_nettype none
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DIV_ZERO = 2'd1,
    STATUS_SAT      = 2'd2
  } status_t;

endpackage
`default_nettype wire

### rtl/cau_if.sv
// Valid/ready channel interfaces for operation and result transactions.
`default_nettype none
interface cau_in_if #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic signed [DATA_WIDTH-1:0] a_re;
  logic signed [DATA_WIDTH-1:0] a_im;
  logic signed [DATA_WIDTH-1:0] b_re;
  logic signed [DATA_WIDTH-1:0] b_im;

  modport source (output valid, func, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_re;
  logic signed [DATA_WIDTH-1:0] res_im;
  logic [1:0]                   status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink   (input valid, res_re, res_im, status, output ready);
endinterface
`default_nettype wire

### rtl/complex_arith_unit.sv
// Complex arithmetic unit: pipelined add, subtract, multiply and divide.
// An accepted operation passes stages 1 to 3, the divider stages and the output register.
// Throughput: one transaction per cycle; the whole pipe holds while the result
// register is full and not taken. Depth is set by the restoring divider, one
// quotient bit per stage. Reset (synchronous, rst_n low) clears all valid bits.
`default_nettype none
module complex_arith_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  cau_in_if.sink      in_ch,
  cau_out_if.source   out_ch
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;          // product / magnitude width
  localparam int SW = PW + 1;         // signed sum of two products
  localparam int NW = PW + FRAC_BITS; // scaled numerator magnitude
  localparam int XW = 3 * W;          // divider compare width

  logic adv;
  logic out_valid_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 1: products and sums
  logic                 v1_r;
  cau_pkg::func_t       func1_r;
  logic                 dz1_r;
  logic signed [PW-1:0] p_ac_r, p_bd_r, p_ad_r, p_bc_r, p_cc_r, p_dd_r;
  logic signed [W:0]    as_re_r, as_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func1_r <= cau_pkg::func_t'(in_ch.func);
      dz1_r   <= (in_ch.func == cau_pkg::FUNC_DIV) && (in_ch.b_re == '0) &&
                 (in_ch.b_im == '0);
      p_ac_r  <= PW'(in_ch.a_re) * PW'(in_ch.b_re);
      p_bd_r  <= PW'(in_ch.a_im) * PW'(in_ch.b_im);
      p_ad_r  <= PW'(in_ch.a_re) * PW'(in_ch.b_im);
      p_bc_r  <= PW'(in_ch.a_im) * PW'(in_ch.b_re);
      p_cc_r  <= PW'(in_ch.b_re) * PW'(in_ch.b_re);
      p_dd_r  <= PW'(in_ch.b_im) * PW'(in_ch.b_im);
      if (in_ch.func == cau_pkg::FUNC_SUB) begin
        as_re_r <= (W+1)'(in_ch.a_re) - (W+1)'(in_ch.b_re);
        as_im_r <= (W+1)'(in_ch.a_im) - (W+1)'(in_ch.b_im);
      end else begin
        as_re_r <= (W+1)'(in_ch.a_re) + (W+1)'(in_ch.b_re);
        as_im_r <= (W+1)'(in_ch.a_im) + (W+1)'(in_ch.b_im);
      end
    end
  end

  // Stage 2: combine products, split sign and magnitude, scale numerator, form divisor
  logic signed [SW-1:0] sum_re, sum_im;
  logic [SW-1:0]        abs_re, abs_im;
  logic [NW-1:0]        num_re_nxt, num_im_nxt;
  logic [PW-1:0]        den_nxt;

  always_comb begin
    case (func1_r)
      cau_pkg::FUNC_MUL: begin
        sum_re = SW'(p_ac_r) - SW'(p_bd_r);
        sum_im = SW'(p_ad_r) + SW'(p_bc_r);
      end
      cau_pkg::FUNC_DIV: begin
        sum_re = SW'(p_ac_r) + SW'(p_bd_r);
        sum_im = SW'(p_bc_r) - SW'(p_ad_r);
      end
      default: begin
        sum_re = SW'(as_re_r);
        sum_im = SW'(as_im_r);
      end
    endcase
    abs_re = sum_re[SW-1] ? SW'(-sum_re) : SW'(sum_re);
    abs_im = sum_im[SW-1] ? SW'(-sum_im) : SW'(sum_im);
    den_nxt = PW'(1);
    case (func1_r)
      cau_pkg::FUNC_MUL: begin
        num_re_nxt = NW'(abs_re[PW-1:0] >> FRAC_BITS);
        num_im_nxt = NW'(abs_im[PW-1:0] >> FRAC_BITS);
      end
      cau_pkg::FUNC_DIV: begin
        num_re_nxt = NW'(abs_re[PW-1:0]) << FRAC_BITS;
        num_im_nxt = NW'(abs_im[PW-1:0]) << FRAC_BITS;
        if (!dz1_r) begin
          den_nxt = $unsigned(p_cc_r) + $unsigned(p_dd_r);
        end
      end
      default: begin
        num_re_nxt = NW'(abs_re[PW-1:0]);
        num_im_nxt = NW'(abs_im[PW-1:0]);
      end
    endcase
    if (dz1_r) begin
      num_re_nxt = '0;
      num_im_nxt = '0;
    end
  end

  logic          v2_r, dz2_r, neg_re2_r, neg_im2_r;
  logic [NW-1:0] num_re2_r, num_im2_r;
  logic [PW-1:0] den2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dz2_r     <= dz1_r;
      neg_re2_r <= sum_re[SW-1];
      neg_im2_r <= sum_im[SW-1];
      num_re2_r <= num_re_nxt;
      num_im2_r <= num_im_nxt;
      den2_r    <= den_nxt;
    end
  end

  // Stage 3: flag quotients of 2^W or more, then seed the divider
  logic [W:0]    vq_r;
  logic          dz_r     [0:W];
  logic          neg_re_r [0:W];
  logic          neg_im_r [0:W];
  logic          ovf_re_r [0:W];
  logic          ovf_im_r [0:W];
  logic [PW-1:0] den_r    [0:W];
  logic [NW-1:0] rem_re_r [0:W];
  logic [NW-1:0] rem_im_r [0:W];
  logic [W-1:0]  q_re_r   [0:W];
  logic [W-1:0]  q_im_r   [0:W];
  logic [XW-1:0] den_top;

  assign den_top = {den2_r, {W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r[0] <= 1'b0;
    end else if (adv) begin
      vq_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dz_r[0]     <= dz2_r;
      neg_re_r[0] <= neg_re2_r;
      neg_im_r[0] <= neg_im2_r;
      ovf_re_r[0] <= {{(XW-NW){1'b0}}, num_re2_r} >= den_top;
      ovf_im_r[0] <= {{(XW-NW){1'b0}}, num_im2_r} >= den_top;
      den_r[0]    <= den2_r;
      rem_re_r[0] <= num_re2_r;
      rem_im_r[0] <= num_im2_r;
      q_re_r[0]   <= '0;
      q_im_r[0]   <= '0;
    end
  end

  // Divider stages: one quotient bit each, most significant first
  for (genvar k = 0; k < W; k++) begin : g_div
    localparam int BIT = W - 1 - k;
    logic [XW-1:0] trial, ext_re, ext_im;
    logic          ge_re, ge_im;
    logic [NW-1:0] rem_re_nxt, rem_im_nxt;
    logic [W-1:0]  q_re_nxt, q_im_nxt;

    always_comb begin
      trial      = {{W{1'b0}}, den_r[k]} << BIT;
      ext_re     = {{(XW-NW){1'b0}}, rem_re_r[k]};
      ext_im     = {{(XW-NW){1'b0}}, rem_im_r[k]};
      ge_re      = ext_re >= trial;
      ge_im      = ext_im >= trial;
      rem_re_nxt = ge_re ? NW'(ext_re - trial) : rem_re_r[k];
      rem_im_nxt = ge_im ? NW'(ext_im - trial) : rem_im_r[k];
      q_re_nxt      = q_re_r[k];
      q_im_nxt      = q_im_r[k];
      q_re_nxt[BIT] = ge_re;
      q_im_nxt[BIT] = ge_im;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vq_r[k+1] <= 1'b0;
      end else if (adv) begin
        vq_r[k+1] <= vq_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dz_r[k+1]     <= dz_r[k];
        neg_re_r[k+1] <= neg_re_r[k];
        neg_im_r[k+1] <= neg_im_r[k];
        ovf_re_r[k+1] <= ovf_re_r[k];
        ovf_im_r[k+1] <= ovf_im_r[k];
        den_r[k+1]    <= den_r[k];
        rem_re_r[k+1] <= rem_re_nxt;
        rem_im_r[k+1] <= rem_im_nxt;
        q_re_r[k+1]   <= q_re_nxt;
        q_im_r[k+1]   <= q_im_nxt;
      end
    end
  end

  // Output stage: saturate, restore sign, set status
  localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};

  logic         sat_re, sat_im;
  logic [W-1:0] q_re, q_im, res_re_nxt, res_im_nxt;
  logic [1:0]   status_nxt;

  always_comb begin
    q_re   = q_re_r[W];
    q_im   = q_im_r[W];
    sat_re = ovf_re_r[W] ||
             (neg_re_r[W] ? (q_re[W-1] && (q_re[W-2:0] != '0)) : q_re[W-1]);
    sat_im = ovf_im_r[W] ||
             (neg_im_r[W] ? (q_im[W-1] && (q_im[W-2:0] != '0)) : q_im[W-1]);
    if (sat_re) begin
      res_re_nxt = neg_re_r[W] ? MIN_VAL : MAX_VAL;
    end else begin
      res_re_nxt = neg_re_r[W] ? W'(-q_re) : q_re;
    end
    if (sat_im) begin
      res_im_nxt = neg_im_r[W] ? MIN_VAL : MAX_VAL;
    end else begin
      res_im_nxt = neg_im_r[W] ? W'(-q_im) : q_im;
    end
    if (dz_r[W]) begin
      status_nxt = cau_pkg::STATUS_DIV_ZERO;
    end else if (sat_re || sat_im) begin
      status_nxt = cau_pkg::STATUS_SAT;
    end else begin
      status_nxt = cau_pkg::STATUS_OK;
    end
  end

  logic [W-1:0] res_re_r, res_im_r;
  logic [1:0]   status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vq_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.res_re = res_re_r;
  assign out_ch.res_im = res_im_r;
  assign out_ch.status = status_r;

  // Divider leaves a remainder below the divisor when no overflow was flagged
  a_rem_re : assert property (@(posedge clk) disable iff (!rst_n)
    (vq_r[W] && !ovf_re_r[W]) |->
      ({{(XW-NW){1'b0}}, rem_re_r[W]} < {{W{1'b0}}, den_r[W]}))
    else $error("real remainder not below divisor");

  a_rem_im : assert property (@(posedge clk) disable iff (!rst_n)
    (vq_r[W] && !ovf_im_r[W]) |->
      ({{(XW-NW){1'b0}}, rem_im_r[W]} < {{W{1'b0}}, den_r[W]}))
    else $error("imaginary remainder not below divisor");

  // Divide by zero must return zero parts
  a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == cau_pkg::STATUS_DIV_ZERO)) |->
      ((res_re_r == '0) && (res_im_r == '0)))
    else $error("divide by zero returned nonzero result");

  // Saturated transaction must carry a clamp value in some part
  a_sat_val : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == cau_pkg::STATUS_SAT)) |->
      ((res_re_r == MIN_VAL) || (res_re_r == MAX_VAL) ||
       (res_im_r == MIN_VAL) || (res_im_r == MAX_VAL)))
    else $error("saturated status without clamp value");

endmodule
`default_nettype wire

### verif/cau_checker.sv
// Checker for the complex arithmetic unit: predicts each result and compares it.
`timescale 1ns / 100ps
module cau_checker #(
  parameter int DW   = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC = cau_pkg::FRAC_BITS_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  cau_in_if         in_ch,
  cau_out_if        out_ch,
  output int        fail_count,
  output int        pending
);

  typedef struct {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    cau_pkg::status_t     status;
  } cplx_result_t;

  localparam logic signed [127:0] MAX_VAL = (128'sd1 <<< (DW - 1)) - 128'sd1;
  localparam logic signed [127:0] MIN_VAL = -(128'sd1 <<< (DW - 1));
  localparam logic signed [127:0] SCALE   = 128'sd1 <<< FRAC;

  cplx_result_t result_q[$];

  // Clamp one wide part to the data width and note any clipping
  function automatic logic signed [DW-1:0] clamp_part(input logic signed [127:0] v,
                                                      inout logic clipped);
    if (v > MAX_VAL) begin
      clipped = 1'b1;
      return MAX_VAL[DW-1:0];
    end else if (v < MIN_VAL) begin
      clipped = 1'b1;
      return MIN_VAL[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Exact complex arithmetic in wide intermediates, truncating toward zero
  function automatic cplx_result_t complex_op(input cau_pkg::func_t f,
                                              input logic signed [DW-1:0] ar, ai,
                                              input logic signed [DW-1:0] br, bi);
    logic signed [127:0] re, im, den, xr, xi, yr, yi;
    logic         clipped;
    cplx_result_t r;
    xr = ar; xi = ai; yr = br; yi = bi;
    clipped = 1'b0;
    case (f)
      cau_pkg::FUNC_ADD: begin
        re = xr + yr;
        im = xi + yi;
      end
      cau_pkg::FUNC_SUB: begin
        re = xr - yr;
        im = xi - yi;
      end
      cau_pkg::FUNC_MUL: begin
        re = (xr * yr - xi * yi) / SCALE;
        im = (xr * yi + xi * yr) / SCALE;
      end
      default: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          r.re = '0;
          r.im = '0;
          r.status = cau_pkg::STATUS_DIV_ZERO;
          return r;
        end
        re = ((xr * yr + xi * yi) * SCALE) / den;
        im = ((xi * yr - xr * yi) * SCALE) / den;
      end
    endcase
    r.re = clamp_part(re, clipped);
    r.im = clamp_part(im, clipped);
    r.status = clipped ? cau_pkg::STATUS_SAT : cau_pkg::STATUS_OK;
    return r;
  endfunction

  assign pending = result_q.size();

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    cplx_result_t exp_r;
    if (!rst_n) begin
      result_q.delete();
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        result_q.push_back(complex_op(cau_pkg::func_t'(in_ch.func), in_ch.a_re, in_ch.a_im,
                                      in_ch.b_re, in_ch.b_im));
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result re=%0d im=%0d status=%0d", $time,
                   out_ch.res_re, out_ch.res_im, out_ch.status);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (out_ch.res_re !== exp_r.re || out_ch.res_im !== exp_r.im ||
              out_ch.status !== exp_r.status) begin
            $display("%0t: mismatch expected re=%0d im=%0d status=%0d,",
                     $time, exp_r.re, exp_r.im, exp_r.status,
                     " actual re=%0d im=%0d status=%0d",
                     out_ch.res_re, out_ch.res_im, out_ch.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### verif/tb.sv
// Testbench top for the complex arithmetic unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;

  localparam int DW = cau_pkg::DATA_WIDTH_DEF;
  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE  = 1 <<< cau_pkg::FRAC_BITS_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic calm = 1'b0;
  int   fail_count;
  int   pending;

  cau_in_if  in_ch ();
  cau_out_if out_ch ();

  complex_arith_unit u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  cau_checker u_checker (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                         .fail_count(fail_count), .pending(pending));

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = cau_pkg::FUNC_ADD;
    in_ch.a_re = '0;
    in_ch.a_im = '0;
    in_ch.b_re = '0;
    in_ch.b_im = '0;
    out_ch.ready = 1'b0;
  end

  // Stall the result side about 20 percent of the time, never while calm
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 20);
  end

  // Idle at random unless calm, then present one operation and hold it until the transaction completes
  task automatic send_op(input cau_pkg::func_t f, input logic signed [DW-1:0] ar, ai, br, bi);
    while (!calm && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.a_re <= ar;
    in_ch.a_im <= ai;
    in_ch.b_re <= br;
    in_ch.b_im <= bi;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Pick an operand: extremes, zero, values within four of zero, small raw integers, or fully random bits
  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(9))
      0: return MAXV;
      1: return MINV;
      2: return '0;
      3, 4: return $signed($urandom_range(8 * ONE)) - 4 * ONE;
      5: return $signed($urandom_range(4095)) - 2048;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    cau_pkg::func_t f;
    logic signed [DW-1:0] br, bi;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every operation, extremes, overflow and divide by zero
    send_op(cau_pkg::FUNC_ADD, ONE, -ONE, 2 * ONE, 3 * ONE);
    send_op(cau_pkg::FUNC_ADD, MAXV, MINV, 1, -1);
    send_op(cau_pkg::FUNC_ADD, MINV, MAXV, MINV, MAXV);
    send_op(cau_pkg::FUNC_SUB, 5 * ONE, ONE, 2 * ONE, -ONE);
    send_op(cau_pkg::FUNC_SUB, MINV, MAXV, 1, -1);
    send_op(cau_pkg::FUNC_SUB, '0, '0, MINV, MINV);
    send_op(cau_pkg::FUNC_MUL, 2 * ONE, 3 * ONE, 4 * ONE, -ONE);
    send_op(cau_pkg::FUNC_MUL, MAXV, MAXV, MAXV, MAXV);
    send_op(cau_pkg::FUNC_MUL, MINV, MINV, MINV, MINV);
    send_op(cau_pkg::FUNC_MUL, MINV, '0, MINV, '0);
    send_op(cau_pkg::FUNC_MUL, -3, 7, 5, -1);
    send_op(cau_pkg::FUNC_DIV, 4 * ONE, 2 * ONE, ONE, ONE);
    send_op(cau_pkg::FUNC_DIV, ONE, ONE, '0, '0);
    send_op(cau_pkg::FUNC_DIV, MAXV, MINV, '0, '0);
    send_op(cau_pkg::FUNC_DIV, MAXV, MAXV, 1, '0);
    send_op(cau_pkg::FUNC_DIV, MINV, MINV, MINV, MINV);
    send_op(cau_pkg::FUNC_DIV, -ONE, 3, '0, -7 * ONE);
    send_op(cau_pkg::FUNC_DIV, MAXV, MINV, MAXV, MINV);
    send_op(cau_pkg::FUNC_DIV, '0, '0, MINV, '0);

    // Random operations, with a calm stretch in the middle
    for (int n = 0; n < 1950; n++) begin
      calm = (n >= 800 && n < 1100);
      f = cau_pkg::func_t'($urandom_range(3));
      br = pick_value();
      bi = pick_value();
      if (f == cau_pkg::FUNC_DIV && $urandom_range(19) == 0) begin
        br = '0;
        bi = '0;
      end
      send_op(f, pick_value(), pick_value(), br, bi);
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    // Drain the pipe, then allow for its latency
    while (pending != 0) @(posedge clk);
    repeat (2 * DW + 16) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #3ms;
    $display("tb: failure");
    $finish;
  end
endmodule

### files.f
rtl/cau_pkg.sv
rtl/cau_if.sv
rtl/complex_arith_unit.sv
verif/cau_checker.sv
verif/tb.sv
